// ----- rtl/id3tfe_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ID3 title frame extractor package
// Shared constants and the parser phase type.
// ----------------------------------------------------------------------------
package id3tfe_pkg;

    localparam int unsigned TITLE_MAX = 262;

    localparam int unsigned POS_W   = 30;
    localparam int unsigned FLEN_W  = 9;
    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned CHAR_W  = 7;

    localparam logic [23:0] MAGIC_ID3 = 24'h494433;
    localparam logic [23:0] MAGIC_EA3_LOWER = 24'h656133;
    localparam logic [23:0] MAGIC_EA3_UPPER = 24'h454133;
    localparam logic [23:0] FRAME_ID_HEAD = 24'h544954;
    localparam logic [7:0]  FRAME_ID_TAIL = 8'h32;

    localparam logic [7:0] CHAR_LOW  = 8'h20;
    localparam logic [7:0] CHAR_HIGH = 8'h7f;

    localparam logic [FLEN_W-1:0] HEADER_LEN        = 9'd10;
    localparam logic [FLEN_W-1:0] HEADER_FOOTER_LEN = 9'd20;

    typedef enum logic [2:0] {
        PH_HEADER = 3'd0,
        PH_SCAN   = 3'd1,
        PH_FSIZE  = 3'd2,
        PH_SKIP   = 3'd3,
        PH_BODY   = 3'd4,
        PH_DONE   = 3'd5
    } phase_t;

endpackage

// ----- rtl/id3_title_frame_extractor_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ID3 title frame extractor
// Parses the tag header and emits the printable characters of the first
// TIT2 frame, followed by one end request per file.
// Each accepted byte's result is registered in the output register.
// Throughput: one byte per cycle while no output request is stalled; the parser
// state and the output register both update in the cycle of acceptance.
// Reset: synchronous, active low; clears the parser and the output valid flag.
// ----------------------------------------------------------------------------
module id3_title_frame_extractor_top
    import id3tfe_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [BYTE_W-1:0] s_file_byte,
    input  logic              s_end_of_file,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [CHAR_W-1:0] m_title_char,
    output logic              m_is_end,
    output logic              m_found
);

    localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};
    localparam logic [15:0] TITLE_MAX_V = 16'(TITLE_MAX);

    logic [POS_W-1:0]  pos_reg, pos_next;
    logic [POS_W-1:0]  tag_len_reg, tag_len_next;
    logic              header_ok_reg, header_ok_next;
    logic [23:0]       recent_reg, recent_next;
    phase_t            phase_reg, phase_next;
    logic [FLEN_W-1:0] frame_len_reg, frame_len_next;
    logic [FLEN_W-1:0] body_cnt_reg, body_cnt_next;

    logic              out_valid_reg;
    logic [CHAR_W-1:0] out_char_reg;
    logic              out_end_reg;
    logic              out_found_reg;

    logic              accept;
    logic              have_char;
    logic              end_hit;
    logic              found_hit;
    logic [POS_W-1:0]  tag_shift;
    logic [15:0]       size_acc;
    logic [FLEN_W:0]   body_inc;

    assign s_ready = !out_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    assign tag_shift = {tag_len_reg[POS_W-8:0], 7'b0} | {{(POS_W-BYTE_W){1'b0}}, s_file_byte};
    assign size_acc  = {frame_len_reg, 7'b0} | {8'b0, s_file_byte};
    assign body_inc  = {1'b0, body_cnt_reg} + 10'd1;

    always_comb begin
        pos_next       = pos_reg;
        tag_len_next   = tag_len_reg;
        header_ok_next = header_ok_reg;
        phase_next     = phase_reg;
        frame_len_next = frame_len_reg;
        body_cnt_next  = body_cnt_reg;
        have_char      = 1'b0;
        end_hit        = 1'b0;
        found_hit      = 1'b0;

        case (phase_reg)
            PH_HEADER: begin
                if (pos_reg == 30'd2) begin
                    header_ok_next = ({recent_reg[15:0], s_file_byte} == MAGIC_ID3) ||
                                     ({recent_reg[15:0], s_file_byte} == MAGIC_EA3_LOWER) ||
                                     ({recent_reg[15:0], s_file_byte} == MAGIC_EA3_UPPER);
                end
                if (pos_reg == 30'd5) begin
                    frame_len_next = s_file_byte[4] ? HEADER_FOOTER_LEN : HEADER_LEN;
                end
                if (pos_reg >= 30'd6) begin
                    tag_len_next = tag_shift;
                end
                if (pos_reg >= 30'd9) begin
                    if (header_ok_reg) begin
                        tag_len_next   = tag_shift + {{(POS_W-FLEN_W){1'b0}}, frame_len_reg};
                        phase_next     = PH_SCAN;
                        frame_len_next = '0;
                    end else begin
                        tag_len_next = '0;
                        end_hit      = 1'b1;
                    end
                end
            end
            PH_SCAN: begin
                if (pos_reg >= 30'd13 && recent_reg == FRAME_ID_HEAD &&
                    s_file_byte == FRAME_ID_TAIL && (pos_reg - 30'd3) < tag_len_reg) begin
                    phase_next     = PH_FSIZE;
                    frame_len_next = '0;
                    body_cnt_next  = '0;
                end else if ({1'b0, pos_reg} >= ({1'b0, tag_len_reg} + 31'd2)) begin
                    end_hit = 1'b1;
                end
            end
            PH_FSIZE, PH_SKIP, PH_BODY: begin
                if (pos_reg >= tag_len_reg) begin
                    end_hit   = 1'b1;
                    found_hit = 1'b1;
                end else if (phase_reg == PH_FSIZE) begin
                    frame_len_next = (size_acc > TITLE_MAX_V) ? TITLE_MAX_V[FLEN_W-1:0]
                                                              : size_acc[FLEN_W-1:0];
                    body_cnt_next  = body_inc[FLEN_W-1:0];
                    if (body_inc >= 10'd4) begin
                        body_cnt_next = '0;
                        if (frame_len_next <= 9'd1) begin
                            end_hit   = 1'b1;
                            found_hit = 1'b1;
                        end else begin
                            phase_next = PH_SKIP;
                        end
                    end
                end else if (phase_reg == PH_SKIP) begin
                    body_cnt_next = body_inc[FLEN_W-1:0];
                    if (body_inc >= 10'd3) begin
                        body_cnt_next = '0;
                        phase_next    = PH_BODY;
                    end
                end else begin
                    if (body_inc >= {1'b0, frame_len_reg}) begin
                        end_hit   = 1'b1;
                        found_hit = 1'b1;
                    end else begin
                        have_char     = s_file_byte inside {[CHAR_LOW:CHAR_HIGH]};
                        body_cnt_next = body_inc[FLEN_W-1:0];
                    end
                end
            end
            default: begin
            end
        endcase

        if (phase_reg != PH_DONE && s_end_of_file && !end_hit) begin
            end_hit   = 1'b1;
            have_char = 1'b0;
            found_hit = phase_next inside {PH_FSIZE, PH_SKIP, PH_BODY};
        end

        if (end_hit) begin
            phase_next = PH_DONE;
        end

        recent_next = {recent_reg[15:0], s_file_byte};
        pos_next    = (pos_reg != POS_MAX) ? pos_reg + 30'd1 : pos_reg;

        if (s_end_of_file) begin
            pos_next       = '0;
            tag_len_next   = '0;
            header_ok_next = 1'b0;
            recent_next    = '0;
            phase_next     = PH_HEADER;
            frame_len_next = '0;
            body_cnt_next  = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg       <= '0;
            tag_len_reg   <= '0;
            header_ok_reg <= 1'b0;
            recent_reg    <= '0;
            phase_reg     <= PH_HEADER;
            frame_len_reg <= '0;
            body_cnt_reg  <= '0;
        end else if (accept) begin
            pos_reg       <= pos_next;
            tag_len_reg   <= tag_len_next;
            header_ok_reg <= header_ok_next;
            recent_reg    <= recent_next;
            phase_reg     <= phase_next;
            frame_len_reg <= frame_len_next;
            body_cnt_reg  <= body_cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (accept) begin
            out_valid_reg <= end_hit || have_char;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            out_char_reg  <= end_hit ? '0 : s_file_byte[CHAR_W-1:0];
            out_end_reg   <= end_hit;
            out_found_reg <= end_hit && found_hit;
        end
    end

    assign m_valid      = out_valid_reg;
    assign m_title_char = out_char_reg;
    assign m_is_end     = out_end_reg;
    assign m_found      = out_found_reg;

endmodule

// ----- rtl/id3tfe_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ID3 title frame extractor checker
// Port-level properties of the extractor, bound to the top level.
// ----------------------------------------------------------------------------
module id3tfe_checker
    import id3tfe_pkg::*;
(
    input logic              aclk,
    input logic              aresetn,
    input logic              m_valid,
    input logic              m_ready,
    input logic [CHAR_W-1:0] m_title_char,
    input logic              m_is_end,
    input logic              m_found
);

    // An end request carries no character.
    a_end_no_char: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_is_end) |-> (m_title_char == '0))
        else $error("end request carries a character");

    // Character requests never report the found flag and are printable.
    a_char_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_is_end) |-> (!m_found && m_title_char[6:5] != 2'b00))
        else $error("character request has bad fields");

    // A stalled request stays in place.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_title_char) &&
                                   $stable(m_is_end) && $stable(m_found)))
        else $error("stalled request changed");

    // Reset empties the output register.
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("output valid after reset");

endmodule

bind id3_title_frame_extractor_top id3tfe_checker u_id3tfe_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_title_char (m_title_char),
    .m_is_end     (m_is_end),
    .m_found      (m_found)
);
